// ----- design/abvl_pkg.sv -----
// ----------------------------------------------------------------------------
// abvl_pkg: shared types and codes for the versioned append buffer
// Operation codes, fixed field widths and the control word that walks
// the cell chain.
// ----------------------------------------------------------------------------
package abvl_pkg;

    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 7;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Control word carried alongside a search request through the chain
    typedef struct packed {
        logic active;   // a request sits in this stage
        logic is_read;  // read by index, else lookup by key and time
        logic hit;      // some earlier cell produced an entry
    } t_ctl;

endpackage

// ----- design/abvl_cell.sv -----
// ----------------------------------------------------------------------------
// abvl_cell: one entry of the append buffer
// Holds one record and its valid bit. A search request is registered on its way
// through; the cell replaces the carried best entry when it matches.
// ----------------------------------------------------------------------------
module abvl_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 7,
    parameter int IDX        = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // write side, broadcast to all cells
    input  logic                          i_clear,
    input  logic                          i_wr_en,
    input  logic [CNT_W-1:0]              i_fill,
    input  logic [KEY_BITS-1:0]           i_wr_key,
    input  logic [VALUE_BITS-1:0]         i_wr_value,
    input  logic [abvl_pkg::STAMP_W-1:0]  i_wr_stamp,
    input  logic                          i_wr_tomb,
    // search request from the previous cell
    input  abvl_pkg::t_ctl                i_ctl,
    input  logic [KEY_BITS-1:0]           i_q_key,
    input  logic [abvl_pkg::STAMP_W-1:0]  i_q_stamp,
    input  logic [abvl_pkg::SLOT_W-1:0]   i_q_slot,
    input  logic [KEY_BITS-1:0]           i_h_key,
    input  logic [VALUE_BITS-1:0]         i_h_value,
    input  logic [abvl_pkg::STAMP_W-1:0]  i_h_stamp,
    input  logic                          i_h_tomb,
    // search request to the next cell
    output abvl_pkg::t_ctl                o_ctl,
    output logic [KEY_BITS-1:0]           o_q_key,
    output logic [abvl_pkg::STAMP_W-1:0]  o_q_stamp,
    output logic [abvl_pkg::SLOT_W-1:0]   o_q_slot,
    output logic [KEY_BITS-1:0]           o_h_key,
    output logic [VALUE_BITS-1:0]         o_h_value,
    output logic [abvl_pkg::STAMP_W-1:0]  o_h_stamp,
    output logic                          o_h_tomb
);

    localparam logic [CNT_W-1:0] IDX_F = CNT_W'(IDX);
    localparam logic [31:0]      IDX_S = 32'(IDX);

    logic                          r_valid;
    logic [KEY_BITS-1:0]           r_key;
    logic [VALUE_BITS-1:0]         r_value;
    logic [abvl_pkg::STAMP_W-1:0]  r_stamp;
    logic                          r_tomb;

    abvl_pkg::t_ctl                r_ctl;
    logic [KEY_BITS-1:0]           r_q_key;
    logic [abvl_pkg::STAMP_W-1:0]  r_q_stamp;
    logic [abvl_pkg::SLOT_W-1:0]   r_q_slot;
    logic [KEY_BITS-1:0]           r_h_key;
    logic [VALUE_BITS-1:0]         r_h_value;
    logic [abvl_pkg::STAMP_W-1:0]  r_h_stamp;
    logic                          r_h_tomb;

    logic wr_here;
    logic slot_eq;
    logic key_hit;
    logic match;

    assign wr_here = i_wr_en && (i_fill == IDX_F);
    assign slot_eq = ({{(32 - abvl_pkg::SLOT_W){1'b0}}, i_q_slot} == IDX_S);
    // carried stamp starts at zero, so the first match always takes over;
    // >= lets a later slot win a tie
    assign key_hit = (r_key == i_q_key) && (r_stamp <= i_q_stamp)
                     && (r_stamp >= i_h_stamp);
    assign match   = i_ctl.active && r_valid && (i_ctl.is_read ? slot_eq : key_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (wr_here) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_key   <= i_wr_key;
            r_value <= i_wr_value;
            r_stamp <= i_wr_stamp;
            r_tomb  <= i_wr_tomb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.active  <= i_ctl.active;
            r_ctl.is_read <= i_ctl.is_read;
            r_ctl.hit     <= i_ctl.hit || match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_key   <= i_q_key;
        r_q_stamp <= i_q_stamp;
        r_q_slot  <= i_q_slot;
        if (match) begin
            r_h_key   <= r_key;
            r_h_value <= r_value;
            r_h_stamp <= r_stamp;
            r_h_tomb  <= r_tomb;
        end else begin
            r_h_key   <= i_h_key;
            r_h_value <= i_h_value;
            r_h_stamp <= i_h_stamp;
            r_h_tomb  <= i_h_tomb;
        end
    end

    assign o_ctl     = r_ctl;
    assign o_q_key   = r_q_key;
    assign o_q_stamp = r_q_stamp;
    assign o_q_slot  = r_q_slot;
    assign o_h_key   = r_h_key;
    assign o_h_value = r_h_value;
    assign o_h_stamp = r_h_stamp;
    assign o_h_tomb  = r_h_tomb;

endmodule

// ----- design/append_buffer_versioned_lookup.sv -----
// ----------------------------------------------------------------------------
// append_buffer_versioned_lookup: unsorted append table with timed lookup
// Records live in a row of cells. Insert fills the next free cell, clear
// empties all at once; lookup and read walk the chain one cell per cycle.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+----------------
//   request  | i_op i_key i_value i_stamp i_is_tomb i_slot  | start && !busy
//   result   | o_accepted o_found o_value_out o_key_out     | o_valid strobe
//            | o_stamp_out o_tomb_out o_fill_level          |
//            | o_tomb_total o_is_full                       |
//
// Insert, clear: result in the cycle after the request; one per cycle if idle.
// Lookup and read: the request walks all CAPACITY cells, one per cycle;
//   busy stays high until the result leaves the last cell, so no new
//   request is taken before the walk's result is out.
// Reset clears the valid bits and counters at once; no sweep.
// The receiver cannot stall: o_valid is high for exactly one cycle.
// ----------------------------------------------------------------------------
module append_buffer_versioned_lookup #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [abvl_pkg::OP_W-1:0]     i_op,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    input  logic [abvl_pkg::STAMP_W-1:0]  i_stamp,
    input  logic                          i_is_tomb,
    input  logic [abvl_pkg::SLOT_W-1:0]   i_slot,
    output logic                          o_valid,
    output logic                          o_accepted,
    output logic                          o_found,
    output logic [VALUE_BITS-1:0]         o_value_out,
    output logic [KEY_BITS-1:0]           o_key_out,
    output logic [abvl_pkg::STAMP_W-1:0]  o_stamp_out,
    output logic                          o_tomb_out,
    output logic [$clog2(CAPACITY + 1)-1:0] o_fill_level,
    output logic [$clog2(CAPACITY + 1)-1:0] o_tomb_total,
    output logic                          o_is_full
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic                          accept;
    logic                          walk;
    logic                          wr_en;
    logic                          clr;
    logic                          is_full;

    logic                          r_busy;
    logic                          n_busy;
    logic [CNT_W-1:0]              r_fill;
    logic [CNT_W-1:0]              n_fill;
    logic [CNT_W-1:0]              r_tomb;
    logic [CNT_W-1:0]              n_tomb;
    logic                          r_done;
    logic                          r_acc;

    // stage s feeds cell s; stage CAPACITY is the last cell's output
    abvl_pkg::t_ctl                s_ctl     [CAPACITY+1];
    logic [KEY_BITS-1:0]           s_q_key   [CAPACITY+1];
    logic [abvl_pkg::STAMP_W-1:0]  s_q_stamp [CAPACITY+1];
    logic [abvl_pkg::SLOT_W-1:0]   s_q_slot  [CAPACITY+1];
    logic [KEY_BITS-1:0]           s_h_key   [CAPACITY+1];
    logic [VALUE_BITS-1:0]         s_h_value [CAPACITY+1];
    logic [abvl_pkg::STAMP_W-1:0]  s_h_stamp [CAPACITY+1];
    logic                          s_h_tomb  [CAPACITY+1];

    abvl_pkg::t_ctl                last_ctl;
    logic                          last_hit;

    assign accept  = start && !r_busy;
    assign walk    = (i_op == abvl_pkg::OP_LOOKUP) || (i_op == abvl_pkg::OP_READ);
    assign is_full = (r_fill == CAP_C);
    assign wr_en   = accept && (i_op == abvl_pkg::OP_INSERT) && !is_full;
    assign clr     = accept && (i_op == abvl_pkg::OP_CLEAR);

    assign s_ctl[0].active  = accept && walk;
    assign s_ctl[0].is_read = (i_op == abvl_pkg::OP_READ);
    assign s_ctl[0].hit     = 1'b0;
    assign s_q_key[0]       = i_key;
    assign s_q_stamp[0]     = i_stamp;
    assign s_q_slot[0]      = i_slot;
    assign s_h_key[0]       = '0;
    assign s_h_value[0]     = '0;
    assign s_h_stamp[0]     = '0;
    assign s_h_tomb[0]      = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        abvl_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (clr),
            .i_wr_en    (wr_en),
            .i_fill     (r_fill),
            .i_wr_key   (i_key),
            .i_wr_value (i_value),
            .i_wr_stamp (i_stamp),
            .i_wr_tomb  (i_is_tomb),
            .i_ctl      (s_ctl[g]),
            .i_q_key    (s_q_key[g]),
            .i_q_stamp  (s_q_stamp[g]),
            .i_q_slot   (s_q_slot[g]),
            .i_h_key    (s_h_key[g]),
            .i_h_value  (s_h_value[g]),
            .i_h_stamp  (s_h_stamp[g]),
            .i_h_tomb   (s_h_tomb[g]),
            .o_ctl      (s_ctl[g+1]),
            .o_q_key    (s_q_key[g+1]),
            .o_q_stamp  (s_q_stamp[g+1]),
            .o_q_slot   (s_q_slot[g+1]),
            .o_h_key    (s_h_key[g+1]),
            .o_h_value  (s_h_value[g+1]),
            .o_h_stamp  (s_h_stamp[g+1]),
            .o_h_tomb   (s_h_tomb[g+1])
        );
    end

    assign last_ctl = s_ctl[CAPACITY];
    assign last_hit = last_ctl.active && last_ctl.hit;

    always_comb begin
        n_busy = r_busy;
        if (accept && walk) begin
            n_busy = 1'b1;
        end else if (last_ctl.active) begin
            n_busy = 1'b0;
        end
    end

    always_comb begin
        n_fill = r_fill;
        n_tomb = r_tomb;
        if (clr) begin
            n_fill = '0;
            n_tomb = '0;
        end else if (wr_en) begin
            n_fill = r_fill + CNT_W'(1);
            if (i_is_tomb) begin
                n_tomb = r_tomb + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fill <= '0;
            r_tomb <= '0;
            r_done <= 1'b0;
            r_acc  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fill <= n_fill;
            r_tomb <= n_tomb;
            r_done <= accept && !walk;
            r_acc  <= (i_op == abvl_pkg::OP_CLEAR) || !is_full;
        end
    end

    assign busy         = r_busy;
    assign o_valid      = r_done || last_ctl.active;
    assign o_accepted   = last_ctl.active ? 1'b1 : r_acc;
    assign o_found      = last_hit;
    assign o_value_out  = last_hit ? s_h_value[CAPACITY] : '0;
    assign o_key_out    = last_hit ? s_h_key[CAPACITY]   : '0;
    assign o_stamp_out  = last_hit ? s_h_stamp[CAPACITY] : '0;
    assign o_tomb_out   = last_hit && s_h_tomb[CAPACITY];
    assign o_fill_level = r_fill;
    assign o_tomb_total = r_tomb;
    assign o_is_full    = is_full;

endmodule

// ----- tb/sv/append_buffer_versioned_lookup_test.sv -----
// ----------------------------------------------------------------------------
// append_buffer_versioned_lookup_test: self-checking bench for the append table
// Drives insert, lookup, read and clear requests through the start/busy
// handshake, keeps a shadow copy of the table to predict every result,
// and compares each o_valid strobe field by field in request order.
// ----------------------------------------------------------------------------
module append_buffer_versioned_lookup_test;

    localparam int CAPACITY    = 64;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int CNT_BITS    = 7;
    localparam int SLOT_BITS   = abvl_pkg::SLOT_W;
    localparam int KEY_POOL    = 6;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [abvl_pkg::OP_W-1:0]    op;
        logic [KEY_BITS-1:0]          key;
        logic [VALUE_BITS-1:0]        value;
        logic [abvl_pkg::STAMP_W-1:0] stamp;
        logic                         is_tomb;
        logic [abvl_pkg::SLOT_W-1:0]  slot;
    } t_request;

    typedef struct {
        logic                         accepted;
        logic                         found;
        logic [VALUE_BITS-1:0]        value;
        logic [KEY_BITS-1:0]          key;
        logic [abvl_pkg::STAMP_W-1:0] stamp;
        logic                         tomb;
        logic [CNT_BITS-1:0]          fill;
        logic [CNT_BITS-1:0]          tombs;
        logic                         full;
    } t_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [abvl_pkg::OP_W-1:0]    i_op = abvl_pkg::OP_READ;
    logic [KEY_BITS-1:0]          i_key = '0;
    logic [VALUE_BITS-1:0]        i_value = '0;
    logic [abvl_pkg::STAMP_W-1:0] i_stamp = '0;
    logic                         i_is_tomb = 1'b0;
    logic [abvl_pkg::SLOT_W-1:0]  i_slot = '0;
    logic                         o_valid;
    logic                         o_accepted;
    logic                         o_found;
    logic [VALUE_BITS-1:0]        o_value_out;
    logic [KEY_BITS-1:0]          o_key_out;
    logic [abvl_pkg::STAMP_W-1:0] o_stamp_out;
    logic                         o_tomb_out;
    logic [CNT_BITS-1:0]          o_fill_level;
    logic [CNT_BITS-1:0]          o_tomb_total;
    logic                         o_is_full;

    append_buffer_versioned_lookup #(
        .CAPACITY  (CAPACITY),
        .KEY_BITS  (KEY_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_value     (i_value),
        .i_stamp     (i_stamp),
        .i_is_tomb   (i_is_tomb),
        .i_slot      (i_slot),
        .o_valid     (o_valid),
        .o_accepted  (o_accepted),
        .o_found     (o_found),
        .o_value_out (o_value_out),
        .o_key_out   (o_key_out),
        .o_stamp_out (o_stamp_out),
        .o_tomb_out  (o_tomb_out),
        .o_fill_level(o_fill_level),
        .o_tomb_total(o_tomb_total),
        .o_is_full   (o_is_full)
    );

    always #5 i_clk = ~i_clk;

    // Shadow table
    logic [KEY_BITS-1:0]          shadow_key  [CAPACITY];
    logic [VALUE_BITS-1:0]        table_value [CAPACITY];
    logic [abvl_pkg::STAMP_W-1:0] table_stamp [CAPACITY];
    logic                         table_tomb  [CAPACITY];
    logic                         table_valid [CAPACITY];
    int                           fill_count;
    int                           tomb_count;

    t_result                      pending_results[$];
    logic [KEY_BITS-1:0]          key_pool[KEY_POOL];
    int                           idle_pct;
    int                           mismatch_count = 0;
    int                           result_count = 0;
    int                           cycle_count = 0;

    task automatic clear_table();
        for (int i = 0; i < CAPACITY; i++) begin
            table_valid[i] = 1'b0;
        end
        fill_count = 0;
        tomb_count = 0;
    endtask

    // Applies one request to the shadow table and returns what the block must report
    function automatic t_result predict_table_step(input t_request r);
        t_result res;
        int      hit;
        res = '{accepted: 1'b1, found: 1'b0, value: '0, key: '0, stamp: '0,
                tomb: 1'b0, fill: '0, tombs: '0, full: 1'b0};
        hit = -1;
        case (r.op)
            abvl_pkg::OP_INSERT: begin
                if (fill_count < CAPACITY) begin
                    shadow_key[fill_count]  = r.key;
                    table_value[fill_count] = r.value;
                    table_stamp[fill_count] = r.stamp;
                    table_tomb[fill_count]  = r.is_tomb;
                    table_valid[fill_count] = 1'b1;
                    fill_count++;
                    if (r.is_tomb) tomb_count++;
                end else begin
                    res.accepted = 1'b0;
                end
            end
            abvl_pkg::OP_LOOKUP: begin
                // newest stamp not after the query; ties go to the higher slot
                for (int i = 0; i < fill_count; i++) begin
                    if (table_valid[i] && shadow_key[i] == r.key && table_stamp[i] <= r.stamp
                        && (hit < 0 || table_stamp[i] >= table_stamp[hit])) begin
                        hit = i;
                    end
                end
            end
            abvl_pkg::OP_READ: begin
                if (r.slot < CAPACITY && table_valid[r.slot]) hit = int'(r.slot);
            end
            abvl_pkg::OP_CLEAR: begin
                for (int i = 0; i < CAPACITY; i++) table_valid[i] = 1'b0;
                fill_count = 0;
                tomb_count = 0;
            end
            default: ;
        endcase
        if (hit >= 0) begin
            res.found = 1'b1;
            res.value = table_value[hit];
            res.key   = shadow_key[hit];
            res.stamp = table_stamp[hit];
            res.tomb  = table_tomb[hit];
        end
        res.fill  = fill_count[CNT_BITS-1:0];
        res.tombs = tomb_count[CNT_BITS-1:0];
        res.full  = (fill_count == CAPACITY);
        return res;
    endfunction

    function automatic t_request make_request(input logic [abvl_pkg::OP_W-1:0] op,
                                              input logic [KEY_BITS-1:0] key,
                                              input logic [VALUE_BITS-1:0] value,
                                              input logic [abvl_pkg::STAMP_W-1:0] stamp,
                                              input logic is_tomb,
                                              input logic [abvl_pkg::SLOT_W-1:0] slot);
        t_request r;
        r.op      = op;
        r.key     = key;
        r.value   = value;
        r.stamp   = stamp;
        r.is_tomb = is_tomb;
        r.slot    = slot;
        return r;
    endfunction

    // Mostly pooled keys and small stamps so lookups actually hit
    function automatic t_request random_request();
        t_request    r;
        int unsigned pick;
        pick      = $urandom_range(99);
        r.op      = (pick < 42) ? abvl_pkg::OP_INSERT : (pick < 72) ? abvl_pkg::OP_LOOKUP :
                    (pick < 97) ? abvl_pkg::OP_READ : abvl_pkg::OP_CLEAR;
        r.key     = ($urandom_range(9) < 8) ? key_pool[$urandom_range(KEY_POOL-1)] : $urandom;
        r.value   = $urandom;
        r.stamp   = ($urandom_range(9) < 8) ? $urandom_range(63) : $urandom;
        r.is_tomb = ($urandom_range(3) == 0);
        r.slot    = SLOT_BITS'(($urandom_range(3) == 0) ? $urandom_range(127)
                                                       : $urandom_range(fill_count + 1));
        return r;
    endfunction

    // Called in the time step of a rising edge; leaves start high, or low after idling
    task automatic send_request(input t_request r);
        start     <= 1'b1;
        i_op      <= r.op;
        i_key     <= r.key;
        i_value   <= r.value;
        i_stamp   <= r.stamp;
        i_is_tomb <= r.is_tomb;
        i_slot    <= r.slot;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        pending_results.push_back(predict_table_step(r));
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch on result %0d, %s: got %0h, expected %0h",
                     result_count, what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result strobe", 64'd1, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_accepted !== want.accepted)
                    report_mismatch("accepted", 64'(o_accepted), 64'(want.accepted));
                if (o_found !== want.found)
                    report_mismatch("found", 64'(o_found), 64'(want.found));
                if (o_value_out !== want.value)
                    report_mismatch("value_out", 64'(o_value_out), 64'(want.value));
                if (o_key_out !== want.key)
                    report_mismatch("key_out", 64'(o_key_out), 64'(want.key));
                if (o_stamp_out !== want.stamp)
                    report_mismatch("stamp_out", 64'(o_stamp_out), 64'(want.stamp));
                if (o_tomb_out !== want.tomb)
                    report_mismatch("tomb_out", 64'(o_tomb_out), 64'(want.tomb));
                if (o_fill_level !== want.fill)
                    report_mismatch("fill_level", 64'(o_fill_level), 64'(want.fill));
                if (o_tomb_total !== want.tombs)
                    report_mismatch("tomb_total", 64'(o_tomb_total), 64'(want.tombs));
                if (o_is_full !== want.full)
                    report_mismatch("is_full", 64'(o_is_full), 64'(want.full));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        logic [KEY_BITS-1:0] k;
        k = 32'hA5C3_0F96;
        idle_pct = 0;
        // empty table
        send_request(make_request(abvl_pkg::OP_READ,   '0, '0, '0, 1'b0, 7'd0));
        send_request(make_request(abvl_pkg::OP_LOOKUP, '0, '0, '0, 1'b0, 7'd0));
        // field extremes, stamp zero matches
        send_request(make_request(abvl_pkg::OP_INSERT, '1, '1, '1, 1'b1, 7'd127));
        send_request(make_request(abvl_pkg::OP_INSERT, '0, '0, '0, 1'b0, 7'd0));
        send_request(make_request(abvl_pkg::OP_LOOKUP, '0, '1, '0, 1'b1, 7'd127));
        send_request(make_request(abvl_pkg::OP_LOOKUP, '1, '0, 32'hFFFF_FFFE, 1'b0, 7'd0));
        send_request(make_request(abvl_pkg::OP_LOOKUP, '1, '0, '1, 1'b0, 7'd0));
        // equal stamps: later slot wins; older stamp picked by earlier query
        send_request(make_request(abvl_pkg::OP_INSERT, k, 32'd1, 32'd100, 1'b0, 7'd0));
        send_request(make_request(abvl_pkg::OP_INSERT, k, 32'd2, 32'd100, 1'b1, 7'd0));
        send_request(make_request(abvl_pkg::OP_INSERT, k, 32'd3, 32'd50,  1'b0, 7'd0));
        send_request(make_request(abvl_pkg::OP_LOOKUP, k, '0, 32'd100, 1'b0, 7'd0));
        send_request(make_request(abvl_pkg::OP_LOOKUP, k, '0, 32'd99,  1'b0, 7'd0));
        send_request(make_request(abvl_pkg::OP_LOOKUP, k, '0, 32'd49,  1'b0, 7'd0));
        send_request(make_request(abvl_pkg::OP_LOOKUP, k ^ 32'd1, '0, '1, 1'b0, 7'd0));
        // reads: filled, empty, last slot, past capacity
        send_request(make_request(abvl_pkg::OP_READ, '0, '0, '0, 1'b0, 7'd1));
        send_request(make_request(abvl_pkg::OP_READ, '0, '0, '0, 1'b0, 7'd5));
        send_request(make_request(abvl_pkg::OP_READ, '0, '0, '0, 1'b0, 7'd63));
        send_request(make_request(abvl_pkg::OP_READ, '0, '0, '0, 1'b0, 7'd64));
        send_request(make_request(abvl_pkg::OP_READ, '1, '1, '1, 1'b1, 7'd127));
        send_request(make_request(abvl_pkg::OP_CLEAR, '1, '1, '1, 1'b1, 7'd127));
        send_request(make_request(abvl_pkg::OP_READ, '0, '0, '0, 1'b0, 7'd0));
        send_request(make_request(abvl_pkg::OP_LOOKUP, k, '0, '1, 1'b0, 7'd0));
        send_request(make_request(abvl_pkg::OP_INSERT, k, 32'd7, 32'd9, 1'b1, 7'd0));
    endtask

    // Fill to capacity, then hit the refused-insert path
    task automatic test_fill_to_full();
        t_request r;
        idle_pct = 22;
        send_request(make_request(abvl_pkg::OP_CLEAR, $urandom, $urandom, $urandom, 1'b0, 7'd0));
        for (int i = 0; i < CAPACITY; i++) begin
            r = random_request();
            r.op = abvl_pkg::OP_INSERT;
            send_request(r);
        end
        send_request(make_request(abvl_pkg::OP_INSERT, $urandom, $urandom, $urandom, 1'b1, 7'd0));
        send_request(make_request(abvl_pkg::OP_INSERT, $urandom, $urandom, $urandom, 1'b0, 7'd0));
        for (int i = 0; i < 4; i++) begin
            r = random_request();
            r.op = abvl_pkg::OP_LOOKUP;
            send_request(r);
        end
        send_request(make_request(abvl_pkg::OP_READ, '0, '0, '0, 1'b0, 7'd63));
        send_request(make_request(abvl_pkg::OP_READ, '0, '0, '0, 1'b0, 7'd64));
        send_request(make_request(abvl_pkg::OP_CLEAR, '0, '0, '0, 1'b0, 7'd0));
    endtask

    task automatic test_random_phase(input int idle, input int count);
        idle_pct = idle;
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
        for (int i = 0; i < count; i++) send_request(random_request());
    endtask

    initial begin
        idle_pct = 0;
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
        clear_table();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_to_full();
        test_random_phase(0, 140);
        test_random_phase(62, 140);
        test_random_phase(22, 140);
        test_random_phase(0, 140);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered", 64'(pending_results.size()), 64'd0);
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
